### hdl/pta_pkg.sv
`default_nettype none

package pta_pkg;

    // action codes carried on the input tuser
    localparam logic ACT_OBSERVE = 1'b0;
    localparam logic ACT_SWEEP   = 1'b1;

    localparam logic [7:0] AGE_RESET_LIMIT = 8'd10;
    localparam logic [7:0] AGE_FRESH       = 8'd1;
    localparam logic [7:0] AGE_CEILING     = 8'hFF;

    typedef enum logic [1:0] {
        ST_KNOWN    = 2'd0,
        ST_INSERTED = 2'd1,
        ST_FULL     = 2'd2,
        ST_SWEPT    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SWEEP,
        S_FIN
    } t_state;

    // write enables of the two table arrays, sharing one write index
    typedef struct packed {
        logic addr_en;
        logic age_en;
    } t_wr_en;

endpackage

`default_nettype wire

### hdl/pta_store.sv
`default_nettype none

module pta_store #(
    parameter int TABLE_DEPTH = 32
) (
    input  wire                                    i_clk,
    input  wire                                    i_rd_en,
    input  wire  [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] i_rd_idx,
    output logic [63:0]                            o_rd_addr,
    output logic [7:0]                             o_rd_age,
    input  pta_pkg::t_wr_en                        i_wr,
    input  wire  [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] i_wr_idx,
    input  wire  [63:0]                            i_wr_addr,
    input  wire  [7:0]                             i_wr_age
);

    logic [63:0] r_addr_mem [TABLE_DEPTH];
    logic [7:0]  r_age_mem  [TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.addr_en) begin
            r_addr_mem[i_wr_idx] <= i_wr_addr;
        end
        if (i_wr.age_en) begin
            r_age_mem[i_wr_idx] <= i_wr_age;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_addr <= r_addr_mem[i_rd_idx];
            o_rd_age  <= r_age_mem[i_rd_idx];
        end
    end

endmodule

`default_nettype wire

### hdl/presence_table_with_aging.sv
`default_nettype none

// channel   dir  handshake                 payload
// s_axis    in   i_s_axis_tvalid/o_..ready  tdata device_address, tuser action
// m_axis    out  o_m_axis_tvalid/i_..ready  tdata slot/entry/removed, tuser status
// cfg       in   i_cfg_valid/o_cfg_ready    i_cfg_data max_missed_age
//
// An item walks the live slots through the table's single registered read port:
// an observe scans until a match or the end of the live run, a sweep reads
// every live slot and compacts the survivors as it goes.
// Reset empties the table and loads the age limit with 10; no clearing pass.
// Input is refused while an item is at work; a result waiting on the output
// register does not block the next item, only the delivery of its own result.

module presence_table_with_aging #(
    parameter int TABLE_DEPTH = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [63:0] i_s_axis_tdata,   // [63:0] device_address
    input  wire  [0:0]  i_s_axis_tuser,   // [0] action
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [4:0] slot_index, [10:5] entry_count,
                                          // [16:11] removed_count, [23:17] zero
    output logic [1:0]  o_m_axis_tuser,   // [1:0] status
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [7:0]  i_cfg_data        // [7:0] max_missed_age
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    pta_pkg::t_state  r_state, n_state;
    logic [CW-1:0]    r_live, n_live;
    logic [CW-1:0]    r_rd, n_rd;
    logic [IW-1:0]    r_didx, n_didx;
    logic             r_pend, n_pend;
    logic [CW-1:0]    r_wr, n_wr;
    logic [CW-1:0]    r_removed, n_removed;
    logic [63:0]      r_addr, n_addr;
    logic [7:0]       r_max_age;

    pta_pkg::t_status r_res_status, n_res_status;
    logic [4:0]       r_res_slot, n_res_slot;
    logic [5:0]       r_res_count, n_res_count;
    logic [5:0]       r_res_removed, n_res_removed;

    logic             r_out_valid, n_out_valid;
    pta_pkg::t_status r_out_status, n_out_status;
    logic [4:0]       r_out_slot, n_out_slot;
    logic [5:0]       r_out_count, n_out_count;
    logic [5:0]       r_out_removed, n_out_removed;

    logic             rd_en;
    logic [IW-1:0]    rd_idx;
    logic [63:0]      rd_addr;
    logic [7:0]       rd_age;
    pta_pkg::t_wr_en  wr_en;
    logic [IW-1:0]    wr_idx;
    logic [63:0]      wr_addr;
    logic [7:0]       wr_age;

    logic             in_take;
    logic             out_free;
    logic             hit;
    logic             more;
    logic             keep;
    logic             scan_done;
    logic             sweep_done;
    logic [15:0]      didx_w, live_w, live_inc_w, wr_w, removed_w;

    pta_store #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_store (
        .i_clk    (i_clk),
        .i_rd_en  (rd_en),
        .i_rd_idx (rd_idx),
        .o_rd_addr(rd_addr),
        .o_rd_age (rd_age),
        .i_wr     (wr_en),
        .i_wr_idx (wr_idx),
        .i_wr_addr(wr_addr),
        .i_wr_age (wr_age)
    );

    assign o_s_axis_tready = (r_state == pta_pkg::S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    // shared compare unit: address match and age limit on the slot just read
    assign hit        = r_pend && (rd_age != 8'd0) && (rd_addr == r_addr);
    assign keep       = !(rd_age > r_max_age);
    assign more       = (r_rd < r_live);
    assign scan_done  = hit || !more;
    assign sweep_done = !more && !r_pend;

    assign didx_w     = 16'(r_didx);
    assign live_w     = 16'(r_live);
    assign live_inc_w = 16'(r_live) + 16'd1;
    assign wr_w       = 16'(r_wr);
    assign removed_w  = 16'(r_removed);

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'd0, r_out_removed, r_out_count, r_out_slot};
    assign o_m_axis_tuser  = r_out_status;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pta_pkg::S_IDLE: begin
                if (in_take) begin
                    n_state = (i_s_axis_tuser[0] == pta_pkg::ACT_SWEEP)
                            ? pta_pkg::S_SWEEP : pta_pkg::S_SCAN;
                end
            end
            pta_pkg::S_SCAN: begin
                if (scan_done) begin
                    n_state = pta_pkg::S_FIN;
                end
            end
            pta_pkg::S_SWEEP: begin
                if (sweep_done) begin
                    n_state = pta_pkg::S_FIN;
                end
            end
            pta_pkg::S_FIN: begin
                if (out_free) begin
                    n_state = pta_pkg::S_IDLE;
                end
            end
            default: n_state = pta_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_live        = r_live;
        n_rd          = r_rd;
        n_didx        = r_didx;
        n_pend        = 1'b0;
        n_wr          = r_wr;
        n_removed     = r_removed;
        n_addr        = r_addr;
        n_res_status  = r_res_status;
        n_res_slot    = r_res_slot;
        n_res_count   = r_res_count;
        n_res_removed = r_res_removed;
        n_out_valid   = r_out_valid && !i_m_axis_tready;
        n_out_status  = r_out_status;
        n_out_slot    = r_out_slot;
        n_out_count   = r_out_count;
        n_out_removed = r_out_removed;
        rd_en         = 1'b0;
        rd_idx        = r_rd[IW-1:0];
        wr_en         = '0;
        wr_idx        = r_wr[IW-1:0];
        wr_addr       = rd_addr;
        wr_age        = pta_pkg::AGE_FRESH;

        unique case (r_state)
            pta_pkg::S_IDLE: begin
                if (in_take) begin
                    n_addr    = i_s_axis_tdata;
                    n_rd      = '0;
                    n_wr      = '0;
                    n_removed = '0;
                end
            end
            pta_pkg::S_SCAN: begin
                n_res_removed = 6'd0;
                if (hit) begin
                    // refresh the matching entry
                    wr_en.age_en = 1'b1;
                    wr_idx       = r_didx;
                    n_res_status = pta_pkg::ST_KNOWN;
                    n_res_slot   = didx_w[4:0];
                    n_res_count  = live_w[5:0];
                end else if (more) begin
                    rd_en  = 1'b1;
                    n_didx = r_rd[IW-1:0];
                    n_pend = 1'b1;
                    n_rd   = r_rd + CW'(1);
                end else if (r_live < DEPTH_C) begin
                    // append at the end of the live run
                    wr_en.addr_en = 1'b1;
                    wr_en.age_en  = 1'b1;
                    wr_idx        = r_live[IW-1:0];
                    wr_addr       = r_addr;
                    n_live        = r_live + CW'(1);
                    n_res_status  = pta_pkg::ST_INSERTED;
                    n_res_slot    = live_w[4:0];
                    n_res_count   = live_inc_w[5:0];
                end else begin
                    n_res_status = pta_pkg::ST_FULL;
                    n_res_slot   = 5'd0;
                    n_res_count  = live_w[5:0];
                end
            end
            pta_pkg::S_SWEEP: begin
                if (r_pend) begin
                    if (keep) begin
                        // compact the survivor down to the write pointer
                        wr_en.addr_en = 1'b1;
                        wr_en.age_en  = 1'b1;
                        wr_age        = (rd_age == pta_pkg::AGE_CEILING)
                                      ? rd_age : rd_age + 8'd1;
                        n_wr          = r_wr + CW'(1);
                    end else begin
                        n_removed = r_removed + CW'(1);
                    end
                end
                if (more) begin
                    rd_en  = 1'b1;
                    n_didx = r_rd[IW-1:0];
                    n_pend = 1'b1;
                    n_rd   = r_rd + CW'(1);
                end
                if (sweep_done) begin
                    n_live        = r_wr;
                    n_res_status  = pta_pkg::ST_SWEPT;
                    n_res_slot    = 5'd0;
                    n_res_count   = wr_w[5:0];
                    n_res_removed = removed_w[5:0];
                end
            end
            pta_pkg::S_FIN: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_res_status;
                    n_out_slot    = r_res_slot;
                    n_out_count   = r_res_count;
                    n_out_removed = r_res_removed;
                end
            end
            default: begin
                n_live = r_live;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pta_pkg::S_IDLE;
            r_live      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_max_age   <= pta_pkg::AGE_RESET_LIMIT;
        end else begin
            r_state     <= n_state;
            r_live      <= n_live;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_age <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd          <= n_rd;
        r_didx        <= n_didx;
        r_wr          <= n_wr;
        r_removed     <= n_removed;
        r_addr        <= n_addr;
        r_res_status  <= n_res_status;
        r_res_slot    <= n_res_slot;
        r_res_count   <= n_res_count;
        r_res_removed <= n_res_removed;
        r_out_status  <= n_out_status;
        r_out_slot    <= n_out_slot;
        r_out_count   <= n_out_count;
        r_out_removed <= n_out_removed;
    end

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= DEPTH_C)
        else $error("live count beyond table depth");

    a_wr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en.addr_en || wr_en.age_en) |-> (r_state != pta_pkg::S_IDLE))
        else $error("table written while idle");

    a_compact_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pta_pkg::S_SWEEP && wr_en.addr_en) |-> (r_wr < r_rd))
        else $error("sweep write pointer caught up with read pointer");

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> (r_state != pta_pkg::S_IDLE))
        else $error("item taken but sequencer stayed idle");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == pta_pkg::S_FIN))
        else $error("result raised outside the finish step");

endmodule

`default_nettype wire

### test/tb_presence_pkg.sv
package tb_presence_pkg;

    import pta_pkg::*;

    localparam int SLOTS = 32;

    typedef struct packed {
        t_status    status;
        logic [4:0] slot;
        logic [5:0] entries;
        logic [5:0] removed;
    } presence_report_t;

    class presence_scoreboard;
        logic [63:0]      addr_tbl [SLOTS];
        logic [7:0]       age_tbl  [SLOTS];
        int unsigned      live;
        logic [7:0]       age_limit;
        presence_report_t pending_reports [$];
        int unsigned      mismatches;
        int unsigned      items_seen;
        int unsigned      reports_checked;
        int unsigned      status_seen [4];
        int unsigned      dropped_total;
        int unsigned      pinned_at_ceiling;

        function new();
            live              = 0;
            age_limit         = AGE_RESET_LIMIT;
            mismatches        = 0;
            items_seen        = 0;
            reports_checked   = 0;
            dropped_total     = 0;
            pinned_at_ceiling = 0;
            for (int k = 0; k < 4; k++) status_seen[k] = 0;
        endfunction

        function int unsigned reports_outstanding();
            return pending_reports.size();
        endfunction

        // work out the report for one accepted item and advance the table
        function void predict_report(logic act, logic [63:0] addr);
            presence_report_t rpt;
            int unsigned      i;
            int unsigned      wr;
            int unsigned      dropped;
            bit               hit;
            rpt = '0;
            items_seen++;
            if (act == ACT_OBSERVE) begin
                hit = 1'b0;
                for (i = 0; i < live && !hit; i++) begin
                    if (age_tbl[i] != 8'd0 && addr_tbl[i] == addr) begin
                        hit         = 1'b1;
                        age_tbl[i]  = AGE_FRESH;
                        rpt.status  = ST_KNOWN;
                        rpt.slot    = i[4:0];
                    end
                end
                if (!hit) begin
                    if (live < SLOTS) begin
                        addr_tbl[live] = addr;
                        age_tbl[live]  = AGE_FRESH;
                        rpt.status     = ST_INSERTED;
                        rpt.slot       = live[4:0];
                        live++;
                    end else begin
                        rpt.status = ST_FULL;
                    end
                end
            end else begin
                // drop stale entries, compact the rest in order, age the survivors
                wr      = 0;
                dropped = 0;
                for (i = 0; i < live; i++) begin
                    if (age_tbl[i] > age_limit) begin
                        dropped++;
                    end else begin
                        addr_tbl[wr] = addr_tbl[i];
                        if (age_tbl[i] == AGE_CEILING) begin
                            age_tbl[wr] = AGE_CEILING;
                            pinned_at_ceiling++;
                        end else begin
                            age_tbl[wr] = age_tbl[i] + 8'd1;
                        end
                        wr++;
                    end
                end
                live          = wr;
                dropped_total += dropped;
                rpt.status    = ST_SWEPT;
                rpt.removed   = dropped[5:0];
            end
            rpt.entries = live[5:0];
            pending_reports.push_back(rpt);
        endfunction

        function void flag_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10) $display("error: %s", msg);
        endfunction

        function void check_report(logic [1:0] got_status, logic [23:0] got_data);
            presence_report_t want;
            reports_checked++;
            if (pending_reports.size() == 0) begin
                flag_mismatch($sformatf("report %0d arrived with nothing outstanding: status %0d data %h",
                                        reports_checked, got_status, got_data));
                return;
            end
            want = pending_reports.pop_front();
            if (got_status !== want.status || got_data[4:0] !== want.slot ||
                    got_data[10:5] !== want.entries || got_data[16:11] !== want.removed ||
                    got_data[23:17] !== 7'd0) begin
                flag_mismatch($sformatf({"report %0d: expected status %0d slot %0d entries %0d ",
                                         "removed %0d, got status %0d slot %0d entries %0d ",
                                         "removed %0d pad %h"},
                                        reports_checked, want.status, want.slot, want.entries,
                                        want.removed, got_status, got_data[4:0], got_data[10:5],
                                        got_data[16:11], got_data[23:17]));
            end else begin
                status_seen[want.status]++;
            end
        endfunction
    endclass

endpackage

### test/tb_top.sv
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import pta_pkg::*;
    import tb_presence_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = SLOTS + 8;
    localparam int POOL_SIZE    = 48;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = '0;

    int unsigned src_idle_pct  = 6;
    int unsigned sink_idle_pct = 55;
    int unsigned cycle_count   = 0;

    logic [63:0]        device_pool [POOL_SIZE];
    presence_scoreboard board;

    presence_table_with_aging #(
        .TABLE_DEPTH(SLOTS)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("cycle limit of %0d reached with %0d reports outstanding",
                     CYCLE_LIMIT, board.reports_outstanding());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result side: check each accepted result, then pick the next ready at random
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) board.check_report(m_tuser, m_tdata);
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task automatic send_item(input logic act, input logic [63:0] addr);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= addr;
        s_tuser  <= act;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        board.predict_report(act, addr);
    endtask

    // drop valid, then hold until every outstanding result has come back
    task automatic wait_for_reports();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (board.reports_outstanding() != 0) @(posedge clk);
    endtask

    task automatic write_age_limit(input logic [7:0] lim);
        wait_for_reports();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= lim;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        board.age_limit = lim;
    endtask

    // bus scans: bursts of observes drawn from a pool of devices, mostly closed
    // by a sweep; a few stray addresses and unterminated scans mixed in
    task automatic run_scans(input int n_items, input int pool_used);
        int unsigned target;
        int          scan_len;
        int          p;
        target = board.items_seen + n_items;
        for (p = 0; p < POOL_SIZE; p++) device_pool[p] = {$urandom, $urandom};
        device_pool[0] = '0;
        device_pool[1] = '1;
        while (board.items_seen < target) begin
            scan_len = ($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(12);
            for (p = 0; p < scan_len; p++) begin
                if ($urandom_range(19) == 0)
                    send_item(ACT_OBSERVE, {$urandom, $urandom});
                else
                    send_item(ACT_OBSERVE, device_pool[$urandom_range(pool_used - 1)]);
            end
            if ($urandom_range(9) != 0) send_item(ACT_SWEEP, {$urandom, $urandom});
            if ($urandom_range(15) == 0) wait_for_reports();
        end
    endtask

    initial begin
        int k;
        board = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, hits, sweeps with junk address, tiny limits
        send_item(ACT_OBSERVE, 64'h0);
        send_item(ACT_OBSERVE, '1);
        send_item(ACT_OBSERVE, 64'h0);
        send_item(ACT_OBSERVE, {32{2'b01}});
        send_item(ACT_OBSERVE, {32{2'b10}});
        send_item(ACT_SWEEP, '1);
        send_item(ACT_OBSERVE, '1);
        send_item(ACT_SWEEP, {32{2'b10}});
        send_item(ACT_OBSERVE, 64'h8000_0000_0000_0001);
        write_age_limit(8'd1);
        send_item(ACT_SWEEP, 64'h0);
        send_item(ACT_SWEEP, 64'h0);
        send_item(ACT_OBSERVE, 64'h0);
        write_age_limit(8'd0);
        // zero limit empties the table, then sweep it empty once more
        send_item(ACT_SWEEP, 64'h0);
        send_item(ACT_SWEEP, '1);
        send_item(ACT_OBSERVE, 64'h1);
        send_item(ACT_OBSERVE, 64'h1);

        // fill the table, then age everything into the ceiling
        write_age_limit(8'd255);
        for (k = 1; k < SLOTS; k++) send_item(ACT_OBSERVE, {$urandom, $urandom});
        send_item(ACT_OBSERVE, 64'h1);
        send_item(ACT_OBSERVE, 64'h0123_4567_89AB_CDEF);
        for (k = 0; k < 256; k++) send_item(ACT_SWEEP, {$urandom, $urandom});
        send_item(ACT_OBSERVE, 64'hFEDC_BA98_7654_3210);
        send_item(ACT_OBSERVE, 64'h1);
        write_age_limit(8'd254);
        send_item(ACT_SWEEP, 64'h0);
        send_item(ACT_OBSERVE, 64'h0);

        write_age_limit(8'd1);
        run_scans(110, 12);
        write_age_limit(8'd254);
        run_scans(110, 48);
        write_age_limit(8'd0);
        run_scans(60, 8);

        src_idle_pct  = 55;
        sink_idle_pct = 6;
        write_age_limit(8'd255);
        run_scans(110, 48);
        write_age_limit(8'd3);
        run_scans(110, 24);
        write_age_limit(AGE_RESET_LIMIT);
        run_scans(110, 40);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        write_age_limit(8'd2);
        run_scans(110, 16);
        write_age_limit(8'd128);
        run_scans(110, 48);
        write_age_limit(8'd6);
        run_scans(110, 36);

        wait_for_reports();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d items: %0d known, %0d inserted, %0d table full, %0d sweeps",
                 board.items_seen, board.status_seen[ST_KNOWN], board.status_seen[ST_INSERTED],
                 board.status_seen[ST_FULL], board.status_seen[ST_SWEPT]);
        $display("sweeps dropped %0d entries, %0d survivors held at the age ceiling",
                 board.dropped_total, board.pinned_at_ceiling);
        if (board.mismatches == 0 && board.reports_outstanding() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches, %0d reports outstanding",
                     board.mismatches, board.reports_outstanding());
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
